// ----- rtl/utf8_to_bmp_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// utf8 to bmp decoder assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_BMP_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_BMP_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define U2B_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2b assertion failed");
// next-cycle implication, checked out of reset
`define U2B_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u2b assertion failed");
`else
`define U2B_ASSERT_NOW(lbl, ante, cons)
`define U2B_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/u2b_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8 to bmp decoder package
// types and constants shared by the decoder modules
// ----------------------------------------------------------------------------
package u2b_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 16;

  // lowest legal value per sequence length (overlong check)
  localparam logic [CodeW-1:0] MinTwoByte   = 16'h0080;
  localparam logic [CodeW-1:0] MinThreeByte = 16'h0800;
  // surrogate range
  localparam logic [CodeW-1:0] SurrLow      = 16'hD800;
  localparam logic [CodeW-1:0] SurrHigh     = 16'hDFFF;

  // byte class prefixes
  localparam logic [1:0] ContPrefix  = 2'b10;
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;
  localparam logic [4:0] Lead4Prefix = 5'b11110;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CodeW-1:0] code_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_FOUR  = 2'd3
  } seq_kind_t;

  // pending sequence state
  typedef struct packed {
    code_t     acc;
    logic [1:0] remaining;
    seq_kind_t kind;
  } dec_state_t;

  typedef struct packed {
    logic  emit;
    code_t code;
  } dec_result_t;

endpackage

// ----- rtl/u2b_byte_decode.sv -----
// ----------------------------------------------------------------------------
// utf8 to bmp byte decode
// per-byte next-state and result logic of the decoder
// ----------------------------------------------------------------------------
module u2b_byte_decode (
  input  u2b_pkg::byte_t      data_byte,
  input  logic                text_end,
  input  u2b_pkg::dec_state_t cur_state,
  output u2b_pkg::dec_state_t nxt_state,
  output u2b_pkg::dec_result_t result
);
  import u2b_pkg::*;

  logic       is_cont;
  code_t      acc_shift;
  logic [1:0] rem_dec;
  logic       value_ok;

  assign is_cont   = (data_byte[7:6] == ContPrefix);
  // only two- and three-byte values matter, so 16 bits of history suffice
  assign acc_shift = {cur_state.acc[CodeW-7:0], data_byte[5:0]};
  assign rem_dec   = cur_state.remaining - 2'd1;

  always_comb begin
    case (cur_state.kind)
      KIND_TWO:   value_ok = (acc_shift >= MinTwoByte);
      KIND_THREE: value_ok = (acc_shift >= MinThreeByte) &&
                             !((acc_shift >= SurrLow) && (acc_shift <= SurrHigh));
      default:    value_ok = 1'b0;
    endcase
  end

  always_comb begin
    nxt_state   = cur_state;
    result.emit = 1'b0;
    result.code = acc_shift;
    if ((cur_state.remaining != 2'd0) && is_cont) begin
      nxt_state.acc       = acc_shift;
      nxt_state.remaining = rem_dec;
      result.emit         = (rem_dec == 2'd0) && value_ok;
    end else begin
      nxt_state.remaining = 2'd0;
      if (data_byte[7] == 1'b0) begin
        result.emit = 1'b1;
        result.code = {{(CodeW-ByteW){1'b0}}, data_byte};
      end else if (data_byte[7:3] == Lead4Prefix) begin
        nxt_state.acc       = {{(CodeW-3){1'b0}}, data_byte[2:0]};
        nxt_state.remaining = 2'd3;
        nxt_state.kind      = KIND_FOUR;
      end else if (data_byte[7:4] == Lead3Prefix) begin
        nxt_state.acc       = {{(CodeW-4){1'b0}}, data_byte[3:0]};
        nxt_state.remaining = 2'd2;
        nxt_state.kind      = KIND_THREE;
      end else if (data_byte[7:5] == Lead2Prefix) begin
        nxt_state.acc       = {{(CodeW-5){1'b0}}, data_byte[4:0]};
        nxt_state.remaining = 2'd1;
        nxt_state.kind      = KIND_TWO;
      end
    end
    if (text_end) begin
      nxt_state.remaining = 2'd0;
    end
  end

endmodule

// ----- rtl/utf8_to_bmp_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// path: an accepted byte beat passes the byte register, then the code point register
// throughput: one byte per cycle without out_stall, set by the single decode step between the
//   byte and code point registers; the pending-sequence state updates in that same step
// reset: rst_n synchronous active low; clears both valid flags and the sequence state
// ----------------------------------------------------------------------------
// utf8 to bmp decoder unit
// decodes a utf-8 byte stream into basic multilingual plane code points
// ----------------------------------------------------------------------------
`include "utf8_to_bmp_decoder_unit_defines.svh"

module utf8_to_bmp_decoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  // byte input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  u2b_pkg::byte_t in_data_byte,
  input  logic           in_text_end,
  // code point output channel
  output logic           out_valid,
  input  logic           out_stall,
  output u2b_pkg::code_t out_code_point
);
  import u2b_pkg::*;

  // byte register stage
  logic       s1_valid_r, s1_valid_nxt;
  byte_t      s1_byte_r;
  logic       s1_end_r;

  // pending sequence state
  dec_state_t state_r, state_nxt;

  // code point register stage
  logic       out_valid_r, out_valid_nxt;
  code_t      out_code_r;

  // handshake glue
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;
  dec_result_t dec_res;

  // output register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // a held byte is decoded whenever its result has somewhere to go
  assign s1_fire  = s1_valid_r && out_free;
  // byte register refills in the cycle it empties, so stall only on a full pipe
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  u2b_byte_decode u_dec (
    .data_byte (s1_byte_r),
    .text_end  (s1_end_r),
    .cur_state (state_r),
    .nxt_state (state_nxt),
    .result    (dec_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      // dropped sequences and partial bytes leave the slot empty
      out_valid_nxt = s1_fire && dec_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{acc: '0, remaining: 2'd0, kind: KIND_NONE};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_text_end;
    end
    if (s1_fire && dec_res.emit) begin
      out_code_r <= dec_res.code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_r;

  // a pending count never exceeds the length of the sequence it belongs to
  `U2B_ASSERT_NOW(a_rem_le_kind, 1'b1, state_r.remaining <= state_r.kind)
  // no surrogate ever leaves the block
  `U2B_ASSERT_NOW(a_no_surrogate, out_valid_r,
                  (out_code_r < SurrLow) || (out_code_r > SurrHigh))
  // the last byte of a text always leaves the decoder idle
  `U2B_ASSERT_NXT(a_end_idle, s1_fire && s1_end_r, state_r.remaining == 2'd0)
  // input is held back only while the byte register is occupied
  `U2B_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8 to bmp decoder unit testbench
// feeds utf-8 byte beats through the decoder, predicts each code point with a
// local decode model and checks every code point beat in order
// ----------------------------------------------------------------------------
module tb;
  import u2b_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports = 10;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  byte_t in_data_byte;
  logic  in_text_end;
  logic  out_valid;
  logic  out_stall;
  code_t out_code_point;

  // local decode state
  logic [20:0] dec_acc;
  logic [1:0]  dec_left;
  seq_kind_t   dec_kind;

  code_t       pending_code_points [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned bytes_sent;
  bit          idle_enable;

  utf8_to_bmp_decoder_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_text_end    (in_text_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one accepted byte beat through the local decoder
  task automatic decode_byte(input byte_t b, input logic last);
    logic fits;
    if (dec_left != 2'd0 && b[7:6] == ContPrefix) begin
      dec_acc  = {dec_acc[14:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        // overlong and out-of-plane values fail here, four-byte always does
        fits = (dec_kind == KIND_TWO && dec_acc >= MinTwoByte) ||
               (dec_kind == KIND_THREE && dec_acc >= MinThreeByte);
        fits = fits && dec_acc <= 21'h00FFFF &&
               !(dec_acc >= SurrLow && dec_acc <= SurrHigh);
        if (fits) begin
          pending_code_points.push_back(dec_acc[15:0]);
        end
      end
    end else begin
      // fresh byte, any pending sequence is abandoned
      dec_left = 2'd0;
      if (b[7] == 1'b0) begin
        pending_code_points.push_back({8'h00, b});
      end else if (b[7:3] == Lead4Prefix) begin
        dec_acc  = {18'd0, b[2:0]};
        dec_left = 2'd3;
        dec_kind = KIND_FOUR;
      end else if (b[7:4] == Lead3Prefix) begin
        dec_acc  = {17'd0, b[3:0]};
        dec_left = 2'd2;
        dec_kind = KIND_THREE;
      end else if (b[7:5] == Lead2Prefix) begin
        dec_acc  = {16'd0, b[4:0]};
        dec_left = 2'd1;
        dec_kind = KIND_TWO;
      end
    end
    // end of text drops whatever is still unfinished
    if (last) begin
      dec_left = 2'd0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // drive one byte beat at the falling edge and hold it until accepted
  task automatic send_byte(input byte_t b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_text_end  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // encode cp in nbytes, send only the first cut of them
  task automatic send_seq(input logic [20:0] cp, input int nbytes, input int cut);
    byte_t seq [4];
    case (nbytes)
      1: begin
        seq[0] = {1'b0, cp[6:0]};
      end
      2: begin
        seq[0] = {Lead2Prefix, cp[10:6]};
        seq[1] = {ContPrefix, cp[5:0]};
      end
      3: begin
        seq[0] = {Lead3Prefix, cp[15:12]};
        seq[1] = {ContPrefix, cp[11:6]};
        seq[2] = {ContPrefix, cp[5:0]};
      end
      default: begin
        seq[0] = {Lead4Prefix, cp[20:18]};
        seq[1] = {ContPrefix, cp[17:12]};
        seq[2] = {ContPrefix, cp[11:6]};
        seq[3] = {ContPrefix, cp[5:0]};
      end
    endcase
    for (int i = 0; i < cut; i++) begin
      send_byte(seq[i], $urandom_range(0, 31) == 0);
    end
  endtask

  // park the input and let every expected code point come out
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_ascii_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_two_byte_sequences();
    send_byte(8'hC2, 1'b0);  // lowest legal two-byte value
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);  // highest two-byte value
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC1, 1'b0);  // overlong, dropped
    send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_three_byte_sequences();
    send_byte(8'hE0, 1'b0);  // lowest legal three-byte value
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0);  // overlong, dropped
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hED, 1'b0);  // surrogate, dropped
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);  // top of the plane, completed on the last byte
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_four_byte_sequences();
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_stray_and_invalid();
    send_byte(8'h80, 1'b0);  // continuation while idle
    send_byte(8'hFF, 1'b0);  // invalid lead
  endtask

  task automatic test_interrupted_sequences();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);  // ascii abandons the pending sequence
  endtask

  task automatic test_text_end();
    send_byte(8'hC3, 1'b1);  // lead on the last byte is dropped
    send_byte(8'hA9, 1'b0);  // so this one is stray
  endtask

  // mostly well-formed text with random content, plus broken sequences and noise
  task automatic test_random_text(input int unsigned count);
    int unsigned target;
    int unsigned r;
    int          n;
    logic [20:0] cp;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_seq(21'($urandom_range(0, 127)), 1, 1);
      end else if (r < 50) begin
        send_seq(21'($urandom_range(0, 16'h07FF)), 2, 2);
      end else if (r < 75) begin
        if ($urandom_range(0, 7) == 0) begin
          cp = 21'($urandom_range(16'hD700, 16'hE0FF));
        end else begin
          cp = 21'($urandom_range(0, 16'hFFFF));
        end
        send_seq(cp, 3, 3);
      end else if (r < 82) begin
        send_seq(21'($urandom), 4, 4);
      end else if (r < 90) begin
        n = $urandom_range(2, 4);
        send_seq(21'($urandom), n, $urandom_range(1, n - 1));
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  // receiver: runs of ready and stalled cycles
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!idle_enable || $urandom_range(0, 99) < 60) begin
        out_stall <= 1'b0;
        hold = idle_enable ? $urandom_range(0, 7) : 0;
      end else begin
        out_stall <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  // code point checker
  always @(posedge clk) begin
    code_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_code_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected code point beat: got %h", out_code_point);
        end
      end else begin
        want = pending_code_points.pop_front();
        if (out_code_point !== want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("code point mismatch: expected %h got %h", want, out_code_point);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_text_end    = 1'b0;
    dec_acc        = '0;
    dec_left       = 2'd0;
    dec_kind       = KIND_NONE;
    mismatch_count = 0;
    idle_cycles    = 0;
    bytes_sent     = 0;
    idle_enable    = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ascii_bytes();
    test_two_byte_sequences();
    test_three_byte_sequences();
    test_four_byte_sequences();
    test_stray_and_invalid();
    test_interrupted_sequences();
    test_text_end();
    drain_pipeline();

    test_random_text(600);
    drain_pipeline();
    // back-to-back stretch with no idling on either side
    idle_enable = 1'b0;
    test_random_text(150);
    idle_enable = 1'b1;
    test_random_text(150);
    drain_pipeline();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/u2b_pkg.sv
rtl/u2b_byte_decode.sv
rtl/utf8_to_bmp_decoder_unit.sv
bench/tb.sv
